// File: rtl/ccsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the core count scaling controller.
// Depends on nothing; every other file imports it.
package ccsc_pkg;

    localparam int DEF_MAX_CORES      = 64;
    localparam int DEF_UTIL_FRAC_BITS = 8;

    localparam int IDLE_W     = 40;
    localparam int TOTAL_W    = 40;
    localparam int WEIGHTED_W = 48;
    localparam int LIVE_W     = 12;
    localparam int ACTIVE_W   = 7;
    localparam int ACTION_W   = 2;
    localparam int UTIL_W     = 16;

    localparam int PERIOD_W   = 32;
    localparam int MAXC_W     = 7;
    localparam int TPC_W      = 7;
    localparam int HYST_W     = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd100000000;
    localparam logic [MAXC_W-1:0]   MAXC_RESET   = 7'd64;
    localparam logic [TPC_W-1:0]    TPC_RESET    = 7'd56;
    localparam logic [HYST_W-1:0]   HYST_RESET   = 8'd51;

    localparam logic [UTIL_W-1:0]   UTIL_SAT     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_CYCLES    = 2'd0,
        REG_MAX_CORES        = 2'd1,
        REG_THREADS_PER_CORE = 2'd2,
        REG_HYSTERESIS       = 2'd3
    } cfg_reg_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE   = 2'd0,
        ACT_GROW   = 2'd1,
        ACT_SHRINK = 2'd2
    } action_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ccsc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } ccsc_status_t;

endpackage

// File: rtl/ccsc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for measurement items and scaling results.
// Depends on ccsc_pkg for field widths.
interface ccsc_in_if
    import ccsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [IDLE_W-1:0]     idle_delta;
    logic [TOTAL_W-1:0]    total_delta;
    logic [WEIGHTED_W-1:0] weighted_delta;
    logic [LIVE_W-1:0]     live_threads;
    logic [ACTIVE_W-1:0]   active_cores;

    modport source (output valid, idle_delta, total_delta, weighted_delta, live_threads,
                    active_cores, input ready);
    modport sink   (input valid, idle_delta, total_delta, weighted_delta, live_threads,
                    active_cores, output ready);
endinterface

interface ccsc_out_if
    import ccsc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [UTIL_W-1:0]   utilization_q8_8;

    modport source (output valid, action, utilization_q8_8, input ready);
    modport sink   (input valid, action, utilization_q8_8, output ready);
endinterface

// File: rtl/ccsc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: accept, divide, decide and hand off one transaction.
// Depends on ccsc_pkg for the command and status structs.
module ccsc_ctrl
    import ccsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ccsc_status_t status,
    output ccsc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: rtl/ccsc_datapath.sv
`timescale 1ns / 1ps
// Configuration registers, bit-serial divider, ramp-up level memory and result register.
// Depends on ccsc_pkg; driven by ccsc_ctrl through the command struct.
module ccsc_datapath
    import ccsc_pkg::*;
#(
    parameter int MAX_CORES      = DEF_MAX_CORES,
    parameter int UTIL_FRAC_BITS = DEF_UTIL_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IDLE_W-1:0]     idle_delta,
    input  logic [TOTAL_W-1:0]    total_delta,
    input  logic [WEIGHTED_W-1:0] weighted_delta,
    input  logic [LIVE_W-1:0]     live_threads,
    input  logic [ACTIVE_W-1:0]   active_cores,
    input  ccsc_cmd_t             cmd,
    output ccsc_status_t          status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ACTION_W-1:0]   out_action,
    output logic [UTIL_W-1:0]     out_util
);

    localparam int DW    = TOTAL_W + UTIL_FRAC_BITS;
    localparam int CNT_W = $clog2(DW);
    localparam int IDX_W = $clog2(MAX_CORES);
    localparam int HW    = HYST_W + UTIL_FRAC_BITS;
    localparam int SW    = ((HW > UTIL_W) ? HW : UTIL_W) + 1;
    localparam int AW    = 9;

    logic [PERIOD_W-1:0] period_reg;
    logic [MAXC_W-1:0]   max_cores_reg;
    logic [TPC_W-1:0]    tpc_reg;
    logic [HYST_W-1:0]   hyst_reg;

    logic [DW-1:0]       dvd_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [UTIL_W-1:0]   quot_reg;
    logic                sat_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                grow_reg;
    logic [ACTIVE_W-1:0] active_reg;
    logic [LIVE_W-1:0]   live_reg;
    logic [UTIL_W-1:0]   level_reg;
    logic                level_valid_reg;

    logic [UTIL_W-1:0]   mem [MAX_CORES];
    logic [MAX_CORES-1:0] valid_reg;

    logic                out_valid_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [UTIL_W-1:0]   out_util_reg;

    logic [TOTAL_W-1:0]  used;
    logic [AW-1:0]       active_w;
    logic [AW-1:0]       rd_w;
    logic                rd_in_range;
    logic [IDX_W-1:0]    rd_idx;
    logic [AW-1:0]       wr_w;
    logic [IDX_W-1:0]    wr_idx;
    logic                grow_now;

    logic [PERIOD_W:0]   rem_shift;
    logic [PERIOD_W+1:0] diff;
    logic                ge;
    logic [PERIOD_W-1:0] rem_next;

    logic [UTIL_W-1:0]   util;
    logic [UTIL_W-1:0]   level;
    logic [HW-1:0]       hyst_val;
    logic [SW-1:0]       util_sum;
    logic [13:0]         slots;
    logic [13:0]         live2;
    logic                shrink_now;
    action_t             action_now;

    // Operand capture
    always_comb
    begin
        used        = (total_delta > idle_delta) ? (total_delta - idle_delta) : '0;
        active_w    = AW'(active_cores);
        rd_w        = active_w - AW'(1);
        rd_in_range = (rd_w < AW'(MAX_CORES));
        rd_idx      = rd_w[IDX_W-1:0];
        grow_now    = (active_w < AW'(max_cores_reg)) && (active_w < AW'(MAX_CORES)) &&
                      (weighted_delta > WEIGHTED_W'(total_delta));
        wr_w        = AW'(active_reg);
        wr_idx      = wr_w[IDX_W-1:0];
    end

    // Restoring division step
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DW-1]};
        diff      = {1'b0, rem_shift} - {2'b00, period_reg};
        ge        = !diff[PERIOD_W+1];
        rem_next  = ge ? diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
    end

    // Decision
    always_comb
    begin
        util       = sat_reg ? UTIL_SAT : quot_reg;
        level      = level_valid_reg ? level_reg : '0;
        hyst_val   = {hyst_reg, {UTIL_FRAC_BITS{1'b0}}} >> 8;
        util_sum   = SW'(util) + SW'(hyst_val);
        slots      = 14'(active_reg) * 14'(tpc_reg);
        live2      = {1'b0, live_reg, 1'b0};
        shrink_now = (active_reg != '0) && (util_sum < SW'(level)) && (live2 < slots);
        if (grow_reg)
        begin
            action_now = ACT_GROW;
        end
        else if (shrink_now)
        begin
            action_now = ACT_SHRINK;
        end
        else
        begin
            action_now = ACT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RESET;
            max_cores_reg   <= MAXC_RESET;
            tpc_reg         <= TPC_RESET;
            hyst_reg        <= HYST_RESET;
            cnt_reg         <= '0;
            valid_reg       <= '0;
            level_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PERIOD_CYCLES:    period_reg    <= cfg_wdata[PERIOD_W-1:0];
                    REG_MAX_CORES:        max_cores_reg <= cfg_wdata[MAXC_W-1:0];
                    REG_THREADS_PER_CORE: tpc_reg       <= cfg_wdata[TPC_W-1:0];
                    REG_HYSTERESIS:       hyst_reg      <= cfg_wdata[HYST_W-1:0];
                    default:              ;
                endcase
            end
            if (cmd.load)
            begin
                cnt_reg         <= '0;
                level_valid_reg <= valid_reg[rd_idx] && rd_in_range;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.finish && grow_reg)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg    <= {used, {UTIL_FRAC_BITS{1'b0}}};
            rem_reg    <= '0;
            quot_reg   <= '0;
            sat_reg    <= 1'b0;
            grow_reg   <= grow_now;
            active_reg <= active_cores;
            live_reg   <= live_threads;
        end
        else if (cmd.step)
        begin
            dvd_reg  <= dvd_reg << 1;
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[UTIL_W-2:0], ge};
            sat_reg  <= sat_reg | quot_reg[UTIL_W-1];
        end
        if (cmd.finish)
        begin
            out_action_reg <= action_now;
            out_util_reg   <= util;
        end
    end

    // Ramp-up level memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            level_reg <= mem[rd_idx];
        end
        if (cmd.finish && grow_reg)
        begin
            mem[wr_idx] <= util;
        end
    end

    assign status.div_last = (cnt_reg == CNT_W'(DW - 1));
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_action      = out_action_reg;
    assign out_util        = out_util_reg;

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded while output register occupied");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && grow_reg) |-> (AW'(active_reg) < AW'(MAX_CORES)))
        else $error("ramp-up level write outside table");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result not presented after finish");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result appeared without finish");

endmodule

// File: rtl/core_count_scaling_controller_core.sv
`timescale 1ns / 1ps
// Top level of the core count scaling controller.
// Depends on ccsc_pkg, ccsc_if, ccsc_ctrl and ccsc_datapath.

// Each transaction on item is one measurement period; the block answers with exactly one
// transaction on result carrying the scaling action and the Q8.8 utilization. Operands are
// captured at the accepting edge. The bit-serial restoring divider produces one quotient
// bit per cycle, then the decide state chooses the action and loads the result register.
// The decide state holds while the previous result still waits in the output register,
// which delays the next item. The next item is taken once the result is loaded into the
// output register, even if it has not yet been taken. The ramp-up level table
// is cleared at reset through per-entry valid bits, so no clearing pass is needed.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and must only change while
// the block is idle.
module core_count_scaling_controller_core
    import ccsc_pkg::*;
#(
    parameter int MAX_CORES      = DEF_MAX_CORES,
    parameter int UTIL_FRAC_BITS = DEF_UTIL_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ccsc_in_if.sink               item,
    ccsc_out_if.source            result
);

    ccsc_cmd_t    cmd;
    ccsc_status_t status;
    logic         in_ready;

    ccsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ccsc_datapath #(
        .MAX_CORES      (MAX_CORES),
        .UTIL_FRAC_BITS (UTIL_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .idle_delta     (item.idle_delta),
        .total_delta    (item.total_delta),
        .weighted_delta (item.weighted_delta),
        .live_threads   (item.live_threads),
        .active_cores   (item.active_cores),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_action     (result.action),
        .out_util       (result.utilization_q8_8)
    );

    assign item.ready = in_ready;

endmodule
